[rtl/text_cell_glyph_pixel_renderer_top_defines.svh]
`ifndef TEXT_CELL_GLYPH_PIXEL_RENDERER_TOP_DEFINES_SVH
`define TEXT_CELL_GLYPH_PIXEL_RENDERER_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define TCGPR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcgpr: same-cycle check failed");

// check cons in the cycle after ante
`define TCGPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcgpr: next-cycle check failed");

`endif

[rtl/tcgpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcgpr_pkg;

    localparam int FONT_BYTES_DEFAULT = 4096;
    localparam int BIT_IDX_W          = 17;
    localparam int BYTE_IDX_W         = 14;
    localparam int MOD_SHIFT          = 30;

    localparam logic [7:0] CODE_FALLBACK = 8'h1a;
    localparam logic [7:0] ALPHA_FULL    = 8'd255;

    localparam logic [3:0] GLYPH_WIDTH_RESET  = 4'd4;
    localparam logic [4:0] GLYPH_HEIGHT_RESET = 5'd6;
    localparam logic [7:0] BLINK_PERIOD_RESET = 8'd4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TICK   = 2'd1,
        OP_RENDER = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_GLYPH_WIDTH  = 2'd0,
        CFG_GLYPH_HEIGHT = 2'd1,
        CFG_BLINK_PERIOD = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [7:0]  char_code;
        logic [2:0]  cell_flags;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [23:0] backdrop_color;
        logic [2:0]  glyph_x;
        logic [3:0]  glyph_y;
    } item_t;

    typedef struct packed {
        logic [23:0] pixel_color;
    } result_t;

    // floor(s / 255), exact for any s below 65280 (the result is 8 bits)
    function automatic logic [7:0] div255(input logic [15:0] s);
        logic [16:0] t;
        t = 17'(s) + 17'd1 + 17'(s[15:8]);
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

[rtl/tcgpr_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tcgpr_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/text_cell_glyph_pixel_renderer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_glyph_pixel_renderer_top_defines.svh"

// Text-mode character generator for an LED matrix. Each item is a font byte
// load, a frame tick or a pixel render; only a render returns a transaction
// (the blended pixel). Items enter at one per clock while the output is not
// stalled, and a render's pixel passes through eight register stages: the
// input register, glyph row/column products, bit index, the reduction of
// the byte index to the font size (quotient, remainder, correction), the
// single-port font memory read and the output register; the background and
// foreground blends run alongside. Loads and reads meet the font memory in
// the same stage, so a render sees every load accepted before it. A stalled
// output holds the whole pipeline. The font memory has no reset; a render
// must only address bytes that have been loaded.
module text_cell_glyph_pixel_renderer_top
    import tcgpr_pkg::*;
#(
    parameter int FONT_BYTES = FONT_BYTES_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    tcgpr_stream_if.sink      item,
    tcgpr_stream_if.source    result
);

    localparam int ADDR_W  = $clog2(FONT_BYTES);
    localparam int RECIP_W = MOD_SHIFT + 1;
    localparam int PROD_W  = BYTE_IDX_W + RECIP_W;
    localparam int MOD_W   = ((ADDR_W > BYTE_IDX_W) ? ADDR_W : BYTE_IDX_W) + 1;
    localparam int QC_W    = BYTE_IDX_W + MOD_W;
    localparam logic [RECIP_W-1:0] MOD_RECIP =
        RECIP_W'((64'd1 << MOD_SHIFT) / FONT_BYTES);

    logic [3:0] glyph_width_reg;
    logic [4:0] glyph_height_reg;
    logic [7:0] blink_period_reg;
    logic       blink_phase_reg;
    logic [7:0] blink_count_reg;

    logic       adv;
    op_t        in_op;
    logic       tick_acc;
    logic [7:0] code_next;
    logic       flip_next;

    logic s1_load_reg, s1_render_reg;
    logic s2_load_reg, s2_render_reg;
    logic s3_load_reg, s3_render_reg;
    logic s4_load_reg, s4_render_reg;
    logic s5_load_reg, s5_render_reg;
    logic s6_load_reg, s6_render_reg;
    logic s7_render_reg;
    logic out_valid_reg;

    logic [11:0] s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [7:0]  s1_byte_reg, s2_byte_reg, s3_byte_reg, s4_byte_reg, s5_byte_reg;
    logic [7:0]  s6_byte_reg;
    logic [7:0]  s1_code_reg;
    logic [2:0]  s1_gx_reg;
    logic [3:0]  s1_gy_reg;
    logic        s1_flip_reg, s2_flip_reg, s3_flip_reg, s4_flip_reg, s5_flip_reg;
    logic        s6_flip_reg, s7_flip_reg;
    logic [31:0] s1_fg_reg, s2_fg_reg, s3_fg_reg;
    logic [31:0] s1_bg_reg;
    logic [23:0] s1_back_reg;

    logic [8:0]  s2_rowsum_reg, s2_rowsum_next;
    logic [7:0]  s2_colsum_reg, s2_colsum_next;
    logic [2:0][15:0] s2_top_reg, s2_top_next, s2_und_reg, s2_und_next;

    logic [BIT_IDX_W-1:0] s3_bit_idx_reg, s3_bit_idx_next;
    logic [23:0] s3_under_reg, s3_under_next;

    logic [BYTE_IDX_W-1:0] s4_x_reg, s4_x_next, s4_q_reg, s4_q_next;
    logic [PROD_W-1:0]     s4_prod;
    logic [2:0]  s4_bitsel_reg;
    logic [23:0] s4_under_reg;
    logic [2:0][15:0] s4_top_reg, s4_top_next, s4_und_reg, s4_und_next;

    logic [QC_W-1:0]  s5_qc;
    logic [MOD_W-1:0] s5_r0_reg, s5_r0_next;
    logic [2:0]  s5_bitsel_reg, s6_bitsel_reg, s7_bitsel_reg;
    logic [23:0] s5_under_reg, s6_under_reg, s7_under_reg;
    logic [23:0] s5_color_reg, s5_color_next, s6_color_reg, s7_color_reg;

    logic [ADDR_W-1:0] s6_addr_reg, s6_addr_next;
    logic [7:0]        font_mem [FONT_BYTES];
    logic [7:0]        s7_rd_reg;

    logic        out_bit;
    logic [23:0] out_color_reg, out_color_next;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;
    assign in_op      = op_t'(item.data.operation);
    assign tick_acc   = item.valid && adv && (in_op == OP_TICK);

    assign result.valid            = out_valid_reg;
    assign result.data.pixel_color = out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= GLYPH_WIDTH_RESET;
            glyph_height_reg <= GLYPH_HEIGHT_RESET;
            blink_period_reg <= BLINK_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[3:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[4:0];
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_phase_reg <= 1'b0;
            blink_count_reg <= 8'd0;
        end
        else if (tick_acc)
        begin
            if (blink_count_reg <= 8'd1)
            begin
                blink_phase_reg <= !blink_phase_reg;
                blink_count_reg <= blink_period_reg;
            end
            else
            begin
                blink_count_reg <= blink_count_reg - 8'd1;
            end
        end
    end

    always_comb
    begin
        code_next = item.data.char_code[7] ? CODE_FALLBACK
                  : {item.data.cell_flags[0], item.data.char_code[6:0]};
        flip_next = item.data.cell_flags[1]
                  ^ (blink_phase_reg & item.data.cell_flags[2]);
    end

    always_comb
    begin
        s2_rowsum_next = 9'(s1_code_reg[7:4]) * 9'(glyph_height_reg) + 9'(s1_gy_reg);
        s2_colsum_next = 8'(s1_code_reg[3:0]) * 8'(glyph_width_reg) + 8'(s1_gx_reg);
        for (int c = 0; c < 3; c++)
        begin
            s2_top_next[c] = 16'(s1_bg_reg[8*c +: 8]) * 16'(s1_bg_reg[31:24]);
            s2_und_next[c] = 16'(s1_back_reg[8*c +: 8])
                           * 16'(ALPHA_FULL - s1_bg_reg[31:24]);
        end
    end

    always_comb
    begin
        s3_bit_idx_next = BIT_IDX_W'(s2_rowsum_reg) * BIT_IDX_W'({glyph_width_reg, 4'b0000})
                        + BIT_IDX_W'(s2_colsum_reg);
        for (int c = 0; c < 3; c++)
        begin
            s3_under_next[8*c +: 8] = div255(s2_top_reg[c] + s2_und_reg[c]);
        end
    end

    always_comb
    begin
        s4_x_next = s3_load_reg ? BYTE_IDX_W'(s3_addr_reg)
                  : s3_bit_idx_reg[BIT_IDX_W-1:3];
        s4_prod   = PROD_W'(s4_x_next) * PROD_W'(MOD_RECIP);
        s4_q_next = s4_prod[BYTE_IDX_W+MOD_SHIFT-1:MOD_SHIFT];
        for (int c = 0; c < 3; c++)
        begin
            s4_top_next[c] = 16'(s3_fg_reg[8*c +: 8]) * 16'(s3_fg_reg[31:24]);
            s4_und_next[c] = 16'(s3_under_reg[8*c +: 8])
                           * 16'(ALPHA_FULL - s3_fg_reg[31:24]);
        end
    end

    always_comb
    begin
        s5_qc      = QC_W'(s4_q_reg) * QC_W'(FONT_BYTES);
        s5_r0_next = MOD_W'(s4_x_reg) - MOD_W'(s5_qc);
        for (int c = 0; c < 3; c++)
        begin
            s5_color_next[8*c +: 8] = div255(s4_top_reg[c] + s4_und_reg[c]);
        end
    end

    always_comb
    begin
        if (s5_r0_reg >= MOD_W'(FONT_BYTES))
        begin
            s6_addr_next = ADDR_W'(s5_r0_reg - MOD_W'(FONT_BYTES));
        end
        else
        begin
            s6_addr_next = ADDR_W'(s5_r0_reg);
        end
    end

    always_comb
    begin
        out_bit        = s7_rd_reg[s7_bitsel_reg] ^ s7_flip_reg;
        out_color_next = out_bit ? s7_color_reg : s7_under_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_load_reg   <= 1'b0;
            s1_render_reg <= 1'b0;
            s2_load_reg   <= 1'b0;
            s2_render_reg <= 1'b0;
            s3_load_reg   <= 1'b0;
            s3_render_reg <= 1'b0;
            s4_load_reg   <= 1'b0;
            s4_render_reg <= 1'b0;
            s5_load_reg   <= 1'b0;
            s5_render_reg <= 1'b0;
            s6_load_reg   <= 1'b0;
            s6_render_reg <= 1'b0;
            s7_render_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_load_reg   <= item.valid && (in_op == OP_LOAD);
            s1_render_reg <= item.valid && (in_op == OP_RENDER);
            s2_load_reg   <= s1_load_reg;
            s2_render_reg <= s1_render_reg;
            s3_load_reg   <= s2_load_reg;
            s3_render_reg <= s2_render_reg;
            s4_load_reg   <= s3_load_reg;
            s4_render_reg <= s3_render_reg;
            s5_load_reg   <= s4_load_reg;
            s5_render_reg <= s4_render_reg;
            s6_load_reg   <= s5_load_reg;
            s6_render_reg <= s5_render_reg;
            s7_render_reg <= s6_render_reg;
            out_valid_reg <= s7_render_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg <= item.data.load_address;
            s1_byte_reg <= item.data.load_byte;
            s1_code_reg <= code_next;
            s1_gx_reg   <= item.data.glyph_x;
            s1_gy_reg   <= item.data.glyph_y;
            s1_flip_reg <= flip_next;
            s1_fg_reg   <= item.data.fg_color;
            s1_bg_reg   <= item.data.bg_color;
            s1_back_reg <= item.data.backdrop_color;

            s2_addr_reg   <= s1_addr_reg;
            s2_byte_reg   <= s1_byte_reg;
            s2_flip_reg   <= s1_flip_reg;
            s2_fg_reg     <= s1_fg_reg;
            s2_rowsum_reg <= s2_rowsum_next;
            s2_colsum_reg <= s2_colsum_next;
            s2_top_reg    <= s2_top_next;
            s2_und_reg    <= s2_und_next;

            s3_addr_reg    <= s2_addr_reg;
            s3_byte_reg    <= s2_byte_reg;
            s3_flip_reg    <= s2_flip_reg;
            s3_fg_reg      <= s2_fg_reg;
            s3_bit_idx_reg <= s3_bit_idx_next;
            s3_under_reg   <= s3_under_next;

            s4_x_reg      <= s4_x_next;
            s4_q_reg      <= s4_q_next;
            s4_byte_reg   <= s3_byte_reg;
            s4_flip_reg   <= s3_flip_reg;
            s4_bitsel_reg <= s3_bit_idx_reg[2:0];
            s4_under_reg  <= s3_under_reg;
            s4_top_reg    <= s4_top_next;
            s4_und_reg    <= s4_und_next;

            s5_r0_reg     <= s5_r0_next;
            s5_byte_reg   <= s4_byte_reg;
            s5_flip_reg   <= s4_flip_reg;
            s5_bitsel_reg <= s4_bitsel_reg;
            s5_under_reg  <= s4_under_reg;
            s5_color_reg  <= s5_color_next;

            s6_addr_reg   <= s6_addr_next;
            s6_byte_reg   <= s5_byte_reg;
            s6_flip_reg   <= s5_flip_reg;
            s6_bitsel_reg <= s5_bitsel_reg;
            s6_under_reg  <= s5_under_reg;
            s6_color_reg  <= s5_color_reg;

            s7_flip_reg   <= s6_flip_reg;
            s7_bitsel_reg <= s6_bitsel_reg;
            s7_under_reg  <= s6_under_reg;
            s7_color_reg  <= s6_color_reg;

            out_color_reg <= out_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s6_load_reg)
        begin
            font_mem[s6_addr_reg] <= s6_byte_reg;
        end
        if (adv)
        begin
            s7_rd_reg <= font_mem[s6_addr_reg];
        end
    end

    `TCGPR_ASSERT_NEXT(a_render_enters, item.valid && item.ready && (in_op == OP_RENDER), s1_render_reg)
    `TCGPR_ASSERT_NEXT(a_stall_holds_addr, !adv && s6_render_reg, s6_render_reg && $stable(s6_addr_reg))
    `TCGPR_ASSERT_IMPL(a_addr_in_range, s6_load_reg || s6_render_reg, MOD_W'(s6_addr_reg) < MOD_W'(FONT_BYTES))
    `TCGPR_ASSERT_NEXT(a_blink_toggle, tick_acc && (blink_count_reg <= 8'd1), blink_phase_reg != $past(blink_phase_reg))

endmodule

`default_nettype wire

[sim/tb_text_cell_glyph_pixel_renderer_top.sv]
`timescale 1ns / 1ps

module tb_text_cell_glyph_pixel_renderer_top;
    import tcgpr_pkg::*;

    localparam logic [1:0]  OP_SPARE       = 2'd3;
    localparam logic [1:0]  CFG_SPARE      = 2'd3;
    localparam int unsigned ALT_SET_OFFSET = 128;
    localparam int unsigned SHEET_COLS     = 16;
    localparam int unsigned BYTE_BITS      = 8;
    localparam int          PIPE_FLUSH     = 16;
    localparam int          STALL_CYCLES   = 300;
    localparam int          FILL_BYTES     = 32;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    tcgpr_stream_if #(.payload_t(item_t))   item_ch ();
    tcgpr_stream_if #(.payload_t(result_t)) pixel_ch ();

    text_cell_glyph_pixel_renderer_top #(
        .FONT_BYTES (FONT_BYTES_DEFAULT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (pixel_ch)
    );

    // renderer state as the testbench sees it
    logic [7:0]  font_img [FONT_BYTES_DEFAULT];
    bit          font_known [FONT_BYTES_DEFAULT];
    logic [3:0]  cell_w;
    logic [4:0]  cell_h;
    logic [7:0]  blink_len;
    logic        blink_on;
    logic [8:0]  blink_left;
    logic [23:0] pending_pixels [$];

    int          error_count   = 0;
    bit          src_idle_on   = 1'b1;
    bit          snk_idle_on   = 1'b1;
    int unsigned hold_request  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [23:0] blend_over(input logic [31:0] top, input logic [23:0] base,
                                               input logic [7:0] alpha);
        logic [23:0] mix;
        int unsigned a;
        int unsigned b;
        int unsigned v;
        mix = '0;
        if (alpha == ALPHA_FULL)
            return top[23:0];
        if (alpha == 8'd0)
            return base;
        for (int s = 0; s < 24; s += 8)
        begin
            a = top[s +: 8];
            b = base[s +: 8];
            v = (a * alpha + b * (ALPHA_FULL - alpha)) / ALPHA_FULL;
            mix[s +: 8] = v[7:0];
        end
        return mix;
    endfunction

    function automatic int unsigned render_bit(input item_t it);
        int unsigned code;
        code = it.char_code;
        if (code >= ALT_SET_OFFSET)
            code = CODE_FALLBACK;
        else if (it.cell_flags[0])
            code = code + ALT_SET_OFFSET;
        return ((code / SHEET_COLS) * cell_h + it.glyph_y) * (cell_w * SHEET_COLS)
             + (code % SHEET_COLS) * cell_w + it.glyph_x;
    endfunction

    function automatic void advance_renderer(input item_t it);
        int unsigned bit_i;
        int unsigned byte_i;
        logic        lit;
        logic [23:0] under;
        case (it.operation)
            OP_LOAD:
            begin
                font_img[it.load_address]   = it.load_byte;
                font_known[it.load_address] = 1'b1;
            end
            OP_TICK:
            begin
                if (blink_left <= 9'd1)
                begin
                    blink_on   = !blink_on;
                    blink_left = {1'b0, blink_len};
                end
                else
                    blink_left = blink_left - 9'd1;
            end
            OP_RENDER:
            begin
                bit_i = render_bit(it);
                byte_i = (bit_i / BYTE_BITS) % FONT_BYTES_DEFAULT;
                lit = font_img[byte_i][bit_i % BYTE_BITS];
                if (it.cell_flags[1])
                    lit = !lit;
                if (blink_on && it.cell_flags[2])
                    lit = !lit;
                under = blend_over(it.bg_color, it.backdrop_color, it.bg_color[31:24]);
                pending_pixels.push_back(lit ? blend_over(it.fg_color, under, it.fg_color[31:24])
                                             : under);
            end
            default:
                ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input logic [23:0] want,
                                          input logic [23:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 55)
            it.operation = OP_RENDER;
        else if (pick < 75)
            it.operation = OP_LOAD;
        else if (pick < 95)
            it.operation = OP_TICK;
        else
            it.operation = OP_SPARE;
        pick = $urandom_range(9);
        if (pick < 2)
            it.fg_color[31:24] = 8'h00;
        else if (pick < 4)
            it.fg_color[31:24] = ALPHA_FULL;
        pick = $urandom_range(9);
        if (pick < 2)
            it.bg_color[31:24] = 8'h00;
        else if (pick < 4)
            it.bg_color[31:24] = ALPHA_FULL;
        return it;
    endfunction

    function automatic item_t render_item(input logic [7:0] code, input logic [2:0] flags,
                                          input logic [31:0] fg, input logic [31:0] bg,
                                          input logic [2:0] gx, input logic [3:0] gy);
        item_t it;
        it = random_item();
        it.operation  = OP_RENDER;
        it.char_code  = code;
        it.cell_flags = flags;
        it.fg_color   = fg;
        it.bg_color   = bg;
        it.glyph_x    = gx;
        it.glyph_y    = gy;
        return it;
    endfunction

    task automatic send_raw(input item_t it);
        while (src_idle_on && $urandom_range(99) < 32)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        advance_renderer(it);
    endtask

    // load the font byte a render reads first if it has never been loaded
    task automatic send_item(input item_t it);
        item_t       fill;
        int unsigned byte_i;
        if (it.operation == OP_RENDER)
        begin
            byte_i = (render_bit(it) / BYTE_BITS) % FONT_BYTES_DEFAULT;
            if (!font_known[byte_i])
            begin
                fill = random_item();
                fill.operation    = OP_LOAD;
                fill.load_address = 12'(byte_i);
                fill.load_byte    = 8'($urandom);
                send_raw(fill);
            end
        end
        send_raw(it);
    endtask

    task automatic send_load(input logic [11:0] addr, input logic [7:0] value);
        item_t it;
        it = random_item();
        it.operation    = OP_LOAD;
        it.load_address = addr;
        it.load_byte    = value;
        send_item(it);
    endtask

    task automatic send_op(input logic [1:0] op);
        item_t it;
        it = random_item();
        it.operation = op;
        send_item(it);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_item(random_item());
    endtask

    task automatic drain_pipeline();
        item_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] w, input logic [7:0] h, input logic [7:0] p,
                                input bit poke_spare);
        cfg_write <= 1'b1;
        cfg_index <= CFG_GLYPH_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cell_w = w[3:0];
        cfg_index <= CFG_GLYPH_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cell_h = h[4:0];
        cfg_index <= CFG_BLINK_PERIOD;
        cfg_data  <= p;
        @(posedge clk);
        blink_len = p;
        if (poke_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= 8'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic test_font_fill();
        for (int a = 0; a < FILL_BYTES; a++)
            send_load(12'(a), 8'($urandom));
    endtask

    task automatic test_cell_features();
        for (int f = 0; f < 8; f++)
            send_item(render_item(8'($urandom), 3'(f), $urandom, $urandom,
                                  3'($urandom), 4'($urandom)));
        send_item(render_item(8'd0,   3'd0, 32'hff12_3456, 32'h80ab_cdef, 3'd0, 4'd0));
        send_item(render_item(8'd127, 3'd1, 32'h4000_ff00, 32'hff00_00ff, 3'd7, 4'd15));
        send_item(render_item(8'd128, 3'd1, 32'h01ff_ffff, 32'hfe00_0000, 3'd7, 4'd0));
        send_item(render_item(8'd255, 3'd2, 32'h0000_0000, 32'h0000_0000, 3'd0, 4'd15));
        // blink phase goes on with the first tick
        send_op(OP_TICK);
        for (int f = 4; f < 8; f++)
            send_item(render_item(8'($urandom), 3'(f), $urandom, $urandom,
                                  3'($urandom), 4'($urandom)));
        send_op(OP_SPARE);
        send_load(12'd0, 8'hff);
        send_load(12'hfff, 8'h00);
        send_item(render_item(8'd0, 3'd0, 32'hff00_ff00, 32'hffff_0000, 3'd0, 4'd0));
        repeat (4)
            send_op(OP_TICK);
        send_item(render_item(8'd1, 3'd4, 32'hff55_aa55, 32'h7f00_0000, 3'd1, 4'd2));
    endtask

    task automatic test_geometry_sweep();
        logic [7:0] geo [0:4][0:2] = '{
            '{8'd1,   8'd1,   8'd1},
            '{8'd8,   8'd16,  8'd255},
            '{8'd0,   8'd0,   8'd0},
            '{8'd15,  8'd31,  8'd2},
            '{8'hf3,  8'he5,  8'd7}
        };
        for (int i = 0; i < 5; i++)
        begin
            drain_pipeline();
            program_regs(geo[i][0], geo[i][1], geo[i][2], i == 0);
            run_random(25);
        end
        repeat (2)
        begin
            drain_pipeline();
            program_regs(8'($urandom_range(8, 1)), 8'($urandom_range(16, 1)),
                         8'($urandom_range(6, 1)), 1'b0);
            run_random(25);
        end
    endtask

    task automatic test_back_to_back();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        run_random(100);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        item_t it;
        hold_request = STALL_CYCLES;
        src_idle_on  = 1'b0;
        repeat (60)
        begin
            it = random_item();
            if ($urandom_range(3) != 0)
                it.operation = OP_RENDER;
            send_item(it);
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        drain_pipeline();
        program_regs(8'($urandom_range(8, 1)), 8'($urandom_range(16, 1)),
                     8'($urandom_range(255, 1)), 1'b1);
        run_random(80);
    endtask

    initial
    begin : pixel_sink
        int unsigned hold_left;
        hold_left = 0;
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                pixel_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                pixel_ch.ready <= !(snk_idle_on && $urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
    begin : pixel_check
        logic [23:0] want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            if (pending_pixels.size() == 0)
                flag_mismatch("unexpected pixel", 24'h0, pixel_ch.data.pixel_color);
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_ch.data.pixel_color !== want)
                    flag_mismatch("pixel_color", want, pixel_ch.data.pixel_color);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("text_cell_glyph_pixel_renderer_top test failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= CFG_GLYPH_WIDTH;
        cfg_data      <= 8'd0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        cell_w     = GLYPH_WIDTH_RESET;
        cell_h     = GLYPH_HEIGHT_RESET;
        blink_len  = BLINK_PERIOD_RESET;
        blink_on   = 1'b0;
        blink_left = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_font_fill();
        test_cell_features();
        test_geometry_sweep();
        test_back_to_back();
        test_output_backpressure();
        test_random_traffic();

        drain_pipeline();
        if (error_count == 0)
            $display("text_cell_glyph_pixel_renderer_top test passed");
        else
            $display("text_cell_glyph_pixel_renderer_top test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tcgpr_pkg.sv
rtl/tcgpr_stream_if.sv
rtl/text_cell_glyph_pixel_renderer_top.sv
sim/tb_text_cell_glyph_pixel_renderer_top.sv
